// File: rtl/ticf_pkg.sv
// shared constants, types and helpers of the topology idle cpu finder
package ticf_pkg;

    localparam int NUM_CPUS      = 64;
    localparam int NUM_LEVELS    = 4;
    localparam int MAX_GROUPS    = 16;

    localparam int ACTIVE_LEVELS = (NUM_LEVELS < 4) ? NUM_LEVELS : 4;
    localparam int SLOTS         = NUM_LEVELS * MAX_GROUPS;
    localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GRP_W         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    localparam int MASK_W        = 64;
    localparam int CPU_W         = 6;
    localparam int LVL_W         = 2;
    localparam int GRP_IN_W      = 4;
    localparam int REQ_W         = 3;
    localparam int CFG_W         = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_REGS      = 4;
    localparam int STATUS_W      = 2;

    localparam int LANE_W        = 8;
    localparam int LANES         = MASK_W / LANE_W;
    localparam int LANE_IDX_W    = 3;

    localparam logic [MASK_W-1:0] CPU_SPAN =
        (NUM_CPUS >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << NUM_CPUS) - MASK_W'(1));

    localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FINISH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MARK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_NEAR   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_GROUP  = 2'd3;

    typedef struct packed {
        logic [MASK_W-1:0] members;
        logic [MASK_W-1:0] idle;
    } entry_t;

    typedef struct packed {
        logic             found;
        logic [CPU_W-1:0] idx;
    } ffs_res_t;

    function automatic logic [SLOT_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [GRP_W-1:0] grp);
        return SLOT_W'(SLOT_W'(lvl) * SLOT_W'(MAX_GROUPS) + SLOT_W'(grp));
    endfunction

endpackage

// File: rtl/ticf_mem.sv
// group mask memory, one write port and one registered read port
module ticf_mem (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ticf_pkg::SLOT_W-1:0] wr_addr,
    input  ticf_pkg::entry_t            wr_data,
    input  logic                        rd_en,
    input  logic [ticf_pkg::SLOT_W-1:0] rd_addr,
    output ticf_pkg::entry_t            rd_data
);

    ticf_pkg::entry_t mem [ticf_pkg::SLOTS];
    ticf_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ticf_ffs.sv
// two-step lowest set bit search over a cpu mask
module ticf_ffs (
    input  logic                        clk,
    input  logic                        load,
    input  logic [ticf_pkg::MASK_W-1:0] word,
    output ticf_pkg::ffs_res_t          res
);

    logic [ticf_pkg::LANES-1:0]      lane_nz_reg;
    logic [ticf_pkg::LANES-1:0]      lane_nz_next;
    logic [ticf_pkg::LANE_IDX_W-1:0] lane_pos_reg  [ticf_pkg::LANES];
    logic [ticf_pkg::LANE_IDX_W-1:0] lane_pos_next [ticf_pkg::LANES];
    logic [ticf_pkg::LANE_IDX_W-1:0] sel;

    // per lane: any bit set, and position of its lowest set bit
    always_comb
    begin
        for (int i = 0; i < ticf_pkg::LANES; i++)
        begin
            lane_nz_next[i]  = |word[i*ticf_pkg::LANE_W +: ticf_pkg::LANE_W];
            lane_pos_next[i] = '0;
            for (int b = ticf_pkg::LANE_W - 1; b >= 0; b--)
            begin
                if (word[i*ticf_pkg::LANE_W + b])
                begin
                    lane_pos_next[i] = ticf_pkg::LANE_IDX_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lane_nz_reg  <= lane_nz_next;
            lane_pos_reg <= lane_pos_next;
        end
    end

    // pick the lowest non-empty lane
    always_comb
    begin
        sel = '0;
        for (int i = ticf_pkg::LANES - 1; i >= 0; i--)
        begin
            if (lane_nz_reg[i])
            begin
                sel = ticf_pkg::LANE_IDX_W'(i);
            end
        end
        res.found = |lane_nz_reg;
        res.idx   = {sel, lane_pos_reg[sel]};
    end

endmodule

// File: rtl/topology_idle_cpu_finder.sv
// top level: request sequencer, config registers and result register
//
// channel  direction  signals
// in       to block   in_valid/in_ready, req_type level group member_mask idle_mask
//                     requester_cpu idle_flag
// out      from block out_valid/out_ready, found cpu_id status
// cfg      to block   cfg_valid/cfg_ready, cfg_index cfg_data (always ready)
//
// one request at a time; load, finish setup and rejected requests answer directly
// own group search: one memory read per group tested at every level
// mark does a read and a write per level, find near a read, search and encode
// per level, push the same per other group visited and a read-state pass per own
// group skipped or level left, all through the group memory's single read port
// group memory has no reset; rst_n clears ready and sets group counts to 1
// a new request is taken while a result still waits; the next result waits for it
module topology_idle_cpu_finder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ticf_pkg::REQ_W-1:0]     req_type,
    input  logic [ticf_pkg::LVL_W-1:0]     level,
    input  logic [ticf_pkg::GRP_IN_W-1:0]  group,
    input  logic [ticf_pkg::MASK_W-1:0]    member_mask,
    input  logic [ticf_pkg::MASK_W-1:0]    idle_mask,
    input  logic [ticf_pkg::CPU_W-1:0]     requester_cpu,
    input  logic                           idle_flag,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [ticf_pkg::CPU_W-1:0]     cpu_id,
    output logic [ticf_pkg::STATUS_W-1:0]  status,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ticf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ticf_pkg::CFG_W-1:0]     cfg_data
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_OWN_RD  = 4'd1;
    localparam logic [3:0] ST_OWN_DAT = 4'd2;
    localparam logic [3:0] ST_MK_RD   = 4'd3;
    localparam logic [3:0] ST_MK_WR   = 4'd4;
    localparam logic [3:0] ST_NR_RD   = 4'd5;
    localparam logic [3:0] ST_FF_DAT  = 4'd6;
    localparam logic [3:0] ST_FF_ENC  = 4'd7;
    localparam logic [3:0] ST_PS_RD   = 4'd8;
    localparam logic [3:0] ST_RESP    = 4'd9;

    localparam logic [ticf_pkg::LVL_W-1:0] LAST_LVL =
        ticf_pkg::LVL_W'(ticf_pkg::ACTIVE_LEVELS - 1);

    logic [3:0]                      state_reg,      state_next;
    logic [ticf_pkg::REQ_W-1:0]      req_reg,        req_next;
    logic [ticf_pkg::CPU_W-1:0]      cpu_reg,        cpu_next;
    logic                            flag_reg,       flag_next;
    logic [ticf_pkg::LVL_W-1:0]      lvl_reg,        lvl_next;
    logic [ticf_pkg::CFG_W-1:0]      grp_reg,        grp_next;
    logic [ticf_pkg::GRP_W-1:0]      owns_reg   [ticf_pkg::CFG_REGS];
    logic [ticf_pkg::GRP_W-1:0]      owns_next  [ticf_pkg::CFG_REGS];
    logic [ticf_pkg::CFG_W-1:0]      groups_reg [ticf_pkg::CFG_REGS];
    logic [ticf_pkg::CFG_W-1:0]      groups_next[ticf_pkg::CFG_REGS];
    logic                            ready_reg,      ready_next;
    logic                            res_found_reg,  res_found_next;
    logic [ticf_pkg::CPU_W-1:0]      res_cpu_reg,    res_cpu_next;
    logic [ticf_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                            out_valid_reg,  out_valid_next;
    logic                            out_found_reg,  out_found_next;
    logic [ticf_pkg::CPU_W-1:0]      out_cpu_reg,    out_cpu_next;
    logic [ticf_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;

    logic [ticf_pkg::CFG_W-1:0]      n_cur;
    logic [ticf_pkg::GRP_W-1:0]      own_grp;
    logic [ticf_pkg::SLOT_W-1:0]     own_slot;
    logic [ticf_pkg::SLOT_W-1:0]     cur_slot;
    logic [ticf_pkg::MASK_W-1:0]     cpu_bit;

    logic                            mem_wr_en;
    logic [ticf_pkg::SLOT_W-1:0]     mem_wr_addr;
    ticf_pkg::entry_t                mem_wr_data;
    logic                            mem_rd_en;
    logic [ticf_pkg::SLOT_W-1:0]     mem_rd_addr;
    ticf_pkg::entry_t                mem_rd_data;
    logic                            ffs_load;
    logic [ticf_pkg::MASK_W-1:0]     ffs_word;
    ticf_pkg::ffs_res_t              ffs_res;

    ticf_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign ffs_word = mem_rd_data.members & mem_rd_data.idle & ticf_pkg::CPU_SPAN;

    ticf_ffs u_ffs (
        .clk  (clk),
        .load (ffs_load),
        .word (ffs_word),
        .res  (ffs_res)
    );

    // groups in use at the current level, clamped to the table size
    always_comb
    begin
        if (32'(groups_reg[lvl_reg]) > ticf_pkg::MAX_GROUPS)
        begin
            n_cur = ticf_pkg::CFG_W'(ticf_pkg::MAX_GROUPS);
        end
        else
        begin
            n_cur = groups_reg[lvl_reg];
        end
    end

    assign own_grp  = owns_reg[lvl_reg];
    assign own_slot = ticf_pkg::slot_addr(lvl_reg, own_grp);
    assign cur_slot = ticf_pkg::slot_addr(lvl_reg, ticf_pkg::GRP_W'(grp_reg));
    assign cpu_bit  = ticf_pkg::MASK_W'(1) << cpu_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign cpu_id    = out_cpu_reg;
    assign status    = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        cpu_next        = cpu_reg;
        flag_next       = flag_reg;
        lvl_next        = lvl_reg;
        grp_next        = grp_reg;
        owns_next       = owns_reg;
        groups_next     = groups_reg;
        ready_next      = ready_reg;
        res_found_next  = res_found_reg;
        res_cpu_next    = res_cpu_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_cpu_next    = out_cpu_reg;
        out_status_next = out_status_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = own_slot;
        mem_wr_data     = mem_rd_data;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = cur_slot;
        ffs_load        = 1'b0;

        if (cfg_valid)
        begin
            groups_next[cfg_index] = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = req_type;
                    cpu_next        = requester_cpu;
                    flag_next       = idle_flag;
                    lvl_next        = '0;
                    grp_next        = '0;
                    res_found_next  = 1'b0;
                    res_cpu_next    = '0;
                    res_status_next = ticf_pkg::STAT_OK;
                    state_next      = ST_RESP;
                    unique case (req_type) inside
                        ticf_pkg::REQ_LOAD:
                        begin
                            if (32'(level) < ticf_pkg::ACTIVE_LEVELS &&
                                32'(group) < ticf_pkg::MAX_GROUPS)
                            begin
                                mem_wr_en           = 1'b1;
                                mem_wr_addr         = ticf_pkg::slot_addr(level,
                                                          ticf_pkg::GRP_W'(group));
                                mem_wr_data.members = member_mask & ticf_pkg::CPU_SPAN;
                                mem_wr_data.idle    = idle_mask & ticf_pkg::CPU_SPAN;
                            end
                        end
                        ticf_pkg::REQ_FINISH:
                        begin
                            ready_next = 1'b1;
                        end
                        ticf_pkg::REQ_MARK, ticf_pkg::REQ_NEAR, ticf_pkg::REQ_PUSH:
                        begin
                            if (!ready_reg)
                            begin
                                res_status_next = ticf_pkg::STAT_NOT_READY;
                            end
                            else if (32'(requester_cpu) >= ticf_pkg::NUM_CPUS)
                            begin
                                res_status_next = ticf_pkg::STAT_NO_GROUP;
                            end
                            else
                            begin
                                state_next = ST_OWN_RD;
                            end
                        end
                        default:
                        begin
                            res_status_next = ticf_pkg::STAT_OK;
                        end
                    endcase
                end
            end

            // own group search: first group in use holding the cpu, level by level
            ST_OWN_RD:
            begin
                if (grp_reg >= n_cur)
                begin
                    res_status_next = ticf_pkg::STAT_NO_GROUP;
                    state_next      = ST_RESP;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cur_slot;
                    state_next  = ST_OWN_DAT;
                end
            end

            ST_OWN_DAT:
            begin
                if (mem_rd_data.members[cpu_reg])
                begin
                    owns_next[lvl_reg] = ticf_pkg::GRP_W'(grp_reg);
                    grp_next           = '0;
                    if (lvl_reg == LAST_LVL)
                    begin
                        if (req_reg == ticf_pkg::REQ_MARK)
                        begin
                            lvl_next   = '0;
                            state_next = ST_MK_RD;
                        end
                        else if (req_reg == ticf_pkg::REQ_NEAR)
                        begin
                            lvl_next   = '0;
                            state_next = ST_NR_RD;
                        end
                        else
                        begin
                            lvl_next   = LAST_LVL;
                            state_next = ST_PS_RD;
                        end
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = ST_OWN_RD;
                    end
                end
                else
                begin
                    grp_next   = grp_reg + 1'b1;
                    state_next = ST_OWN_RD;
                end
            end

            // mark: read-modify-write of the idle mask in each own group
            ST_MK_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = own_slot;
                state_next  = ST_MK_WR;
            end

            ST_MK_WR:
            begin
                mem_wr_en           = 1'b1;
                mem_wr_addr         = own_slot;
                mem_wr_data.members = mem_rd_data.members;
                mem_wr_data.idle    = flag_reg ? (mem_rd_data.idle | cpu_bit)
                                               : (mem_rd_data.idle & ~cpu_bit);
                if (lvl_reg == LAST_LVL)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = ST_MK_RD;
                end
            end

            ST_NR_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = own_slot;
                state_next  = ST_FF_DAT;
            end

            ST_FF_DAT:
            begin
                ffs_load   = 1'b1;
                state_next = ST_FF_ENC;
            end

            ST_FF_ENC:
            begin
                if (ffs_res.found)
                begin
                    res_found_next  = 1'b1;
                    res_cpu_next    = ffs_res.idx;
                    res_status_next = ticf_pkg::STAT_OK;
                    state_next      = ST_RESP;
                end
                else if (req_reg == ticf_pkg::REQ_NEAR)
                begin
                    if (lvl_reg == LAST_LVL)
                    begin
                        res_status_next = ticf_pkg::STAT_NONE;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = ST_NR_RD;
                    end
                end
                else
                begin
                    grp_next   = grp_reg + 1'b1;
                    state_next = ST_PS_RD;
                end
            end

            // push: top level down, other groups in index order
            ST_PS_RD:
            begin
                if (grp_reg >= n_cur)
                begin
                    if (lvl_reg == '0)
                    begin
                        res_status_next = ticf_pkg::STAT_NONE;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - 1'b1;
                        grp_next = '0;
                    end
                end
                else if (grp_reg == ticf_pkg::CFG_W'(own_grp))
                begin
                    grp_next = grp_reg + 1'b1;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cur_slot;
                    state_next  = ST_FF_DAT;
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_cpu_next    = res_cpu_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_reg        <= '0;
            cpu_reg        <= '0;
            flag_reg       <= 1'b0;
            lvl_reg        <= '0;
            grp_reg        <= '0;
            for (int i = 0; i < ticf_pkg::CFG_REGS; i++)
            begin
                owns_reg[i]   <= '0;
                groups_reg[i] <= ticf_pkg::CFG_W'(1);
            end
            ready_reg      <= 1'b0;
            res_found_reg  <= 1'b0;
            res_cpu_reg    <= '0;
            res_status_reg <= ticf_pkg::STAT_OK;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_cpu_reg    <= '0;
            out_status_reg <= ticf_pkg::STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            cpu_reg        <= cpu_next;
            flag_reg       <= flag_next;
            lvl_reg        <= lvl_next;
            grp_reg        <= grp_next;
            owns_reg       <= owns_next;
            groups_reg     <= groups_next;
            ready_reg      <= ready_next;
            res_found_reg  <= res_found_next;
            res_cpu_reg    <= res_cpu_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_found_reg  <= out_found_next;
            out_cpu_reg    <= out_cpu_next;
            out_status_reg <= out_status_next;
        end
    end

    // a found cpu always comes with an ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_found_reg) |-> (out_status_reg == ticf_pkg::STAT_OK))
        else $error("found result without ok status");

    // no cpu number without a hit
    a_cpu_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_cpu_reg == '0))
        else $error("cpu_id nonzero without a hit");

    // a request transfer always starts work, so the input closes next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still open after a request transfer");

endmodule

// File: verif/topology_idle_cpu_finder_test.sv
// testbench of the topology idle cpu finder: directed and random requests against a predictor
module topology_idle_cpu_finder_test;

    typedef struct {
        logic [ticf_pkg::REQ_W-1:0]    kind;
        logic [ticf_pkg::LVL_W-1:0]    lvl;
        logic [ticf_pkg::GRP_IN_W-1:0] grp;
        logic [ticf_pkg::MASK_W-1:0]   members;
        logic [ticf_pkg::MASK_W-1:0]   idlers;
        logic [ticf_pkg::CPU_W-1:0]    cpu;
        logic                          flag;
    } sched_request_t;

    typedef struct packed {
        logic                          found;
        logic [ticf_pkg::CPU_W-1:0]    cpu;
        logic [ticf_pkg::STATUS_W-1:0] status;
    } sched_answer_t;

    typedef enum int {LAYOUT_BLOCKS, LAYOUT_STRIPES, LAYOUT_SCATTER} layout_t;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASE_ITEMS   = 220;
    localparam int SHORT_ITEMS   = 50;
    localparam int RUN_LIMIT     = 8_000_000;
    localparam logic [ticf_pkg::REQ_W-1:0] REQ_TOP = {ticf_pkg::REQ_W{1'b1}};

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [ticf_pkg::REQ_W-1:0]     req_type = '0;
    logic [ticf_pkg::LVL_W-1:0]     level = '0;
    logic [ticf_pkg::GRP_IN_W-1:0]  group = '0;
    logic [ticf_pkg::MASK_W-1:0]    member_mask = '0;
    logic [ticf_pkg::MASK_W-1:0]    idle_mask = '0;
    logic [ticf_pkg::CPU_W-1:0]     requester_cpu = '0;
    logic                           idle_flag = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           found;
    logic [ticf_pkg::CPU_W-1:0]     cpu_id;
    logic [ticf_pkg::STATUS_W-1:0]  status;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ticf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ticf_pkg::CFG_W-1:0]     cfg_data = '0;

    sched_request_t pending_requests[$];
    sched_answer_t  awaited_answers[$];
    sched_request_t on_offer;
    int             error_count = 0;
    bit             req_taken = 1'b0;
    bit             cfg_taken = 1'b0;
    int             src_idle_pct = 0;
    int             sink_idle_pct = 0;
    int             hold_ticket = 0;
    int             hold_seen = 0;
    int             hold_left = 0;

    logic [ticf_pkg::MASK_W-1:0] shadow_members [ticf_pkg::NUM_LEVELS][ticf_pkg::MAX_GROUPS];
    logic [ticf_pkg::MASK_W-1:0] shadow_idle [ticf_pkg::NUM_LEVELS][ticf_pkg::MAX_GROUPS];
    logic [ticf_pkg::CFG_W-1:0]  shadow_groups [ticf_pkg::CFG_REGS];
    bit                          shadow_ready = 1'b0;
    int                          plan_groups [ticf_pkg::CFG_REGS];

    topology_idle_cpu_finder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .level         (level),
        .group         (group),
        .member_mask   (member_mask),
        .idle_mask     (idle_mask),
        .requester_cpu (requester_cpu),
        .idle_flag     (idle_flag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .cpu_id        (cpu_id),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic int groups_in_use(input int lvl);
        return (shadow_groups[lvl] > ticf_pkg::MAX_GROUPS) ? ticf_pkg::MAX_GROUPS
                                                           : int'(shadow_groups[lvl]);
    endfunction

    function automatic int own_group(input int lvl, input logic [ticf_pkg::CPU_W-1:0] cpu);
        int n;
        int g;
        n = groups_in_use(lvl);
        if (cpu >= ticf_pkg::NUM_CPUS)
            return -1;
        for (g = 0; g < n; g++)
            if (shadow_members[lvl][g][cpu])
                return g;
        return -1;
    endfunction

    function automatic int lowest_idle(input int lvl, input int grp);
        logic [ticf_pkg::MASK_W-1:0] m;
        int b;
        m = shadow_members[lvl][grp] & shadow_idle[lvl][grp] & ticf_pkg::CPU_SPAN;
        for (b = 0; b < ticf_pkg::MASK_W; b++)
            if (m[b])
                return b;
        return -1;
    endfunction

    function automatic sched_answer_t idle_cpu_answer(input sched_request_t r);
        sched_answer_t a;
        int owns [ticf_pkg::ACTIVE_LEVELS];
        int hit;
        int l;
        int g;
        int n;
        a = '0;
        hit = -1;
        if (r.kind == ticf_pkg::REQ_LOAD)
        begin
            if (r.lvl < ticf_pkg::ACTIVE_LEVELS && r.grp < ticf_pkg::MAX_GROUPS)
            begin
                shadow_members[r.lvl][r.grp] = r.members & ticf_pkg::CPU_SPAN;
                shadow_idle[r.lvl][r.grp] = r.idlers & ticf_pkg::CPU_SPAN;
            end
        end
        else if (r.kind == ticf_pkg::REQ_FINISH)
        begin
            shadow_ready = 1'b1;
        end
        else if (r.kind == ticf_pkg::REQ_MARK || r.kind == ticf_pkg::REQ_NEAR ||
                 r.kind == ticf_pkg::REQ_PUSH)
        begin
            if (!shadow_ready)
            begin
                a.status = ticf_pkg::STAT_NOT_READY;
            end
            else
            begin
                for (l = 0; l < ticf_pkg::ACTIVE_LEVELS; l++)
                begin
                    owns[l] = own_group(l, r.cpu);
                    if (owns[l] < 0)
                        a.status = ticf_pkg::STAT_NO_GROUP;
                end
                if (a.status == ticf_pkg::STAT_OK && r.kind == ticf_pkg::REQ_MARK)
                begin
                    for (l = 0; l < ticf_pkg::ACTIVE_LEVELS; l++)
                        shadow_idle[l][owns[l]][r.cpu] = r.flag;
                end
                else if (a.status == ticf_pkg::STAT_OK)
                begin
                    if (r.kind == ticf_pkg::REQ_NEAR)
                    begin
                        for (l = 0; l < ticf_pkg::ACTIVE_LEVELS && hit < 0; l++)
                            hit = lowest_idle(l, owns[l]);
                    end
                    else
                    begin
                        // top level first, skipping the requester's own group
                        for (l = ticf_pkg::ACTIVE_LEVELS - 1; l >= 0 && hit < 0; l--)
                        begin
                            n = groups_in_use(l);
                            for (g = 0; g < n && hit < 0; g++)
                                if (g != owns[l])
                                    hit = lowest_idle(l, g);
                        end
                    end
                    if (hit < 0)
                    begin
                        a.status = ticf_pkg::STAT_NONE;
                    end
                    else
                    begin
                        a.found = 1'b1;
                        a.cpu = ticf_pkg::CPU_W'(hit);
                    end
                end
            end
        end
        return a;
    endfunction

    function automatic logic [ticf_pkg::MASK_W-1:0] topology_mask(input layout_t style,
                                                                  input int grp,
                                                                  input int n);
        logic [ticf_pkg::MASK_W-1:0] m;
        int c;
        m = '0;
        for (c = 0; c < ticf_pkg::NUM_CPUS; c++)
        begin
            case (style)
                LAYOUT_BLOCKS:  m[c] = ((c * n) / ticf_pkg::NUM_CPUS) == grp;
                LAYOUT_STRIPES: m[c] = (c % n) == grp;
                default:        m[c] = 1'($urandom_range(1));
            endcase
        end
        return m;
    endfunction

    function automatic logic [ticf_pkg::MASK_W-1:0] idle_pattern();
        logic [ticf_pkg::MASK_W-1:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(5))
            0: m = '0;
            1: m = m & {$urandom, $urandom} & {$urandom, $urandom};
            2: m = m & {$urandom, $urandom};
            3: m = '1;
            default: ;
        endcase
        return m;
    endfunction

    task automatic queue_request(input logic [ticf_pkg::REQ_W-1:0] kind, input int lvl,
                                 input int grp,
                                 input logic [ticf_pkg::MASK_W-1:0] members,
                                 input logic [ticf_pkg::MASK_W-1:0] idlers,
                                 input int cpu, input logic flag);
        sched_request_t r;
        r.kind = kind;
        r.lvl = ticf_pkg::LVL_W'(lvl);
        r.grp = ticf_pkg::GRP_IN_W'(grp);
        r.members = members;
        r.idlers = idlers;
        r.cpu = ticf_pkg::CPU_W'(cpu);
        r.flag = flag;
        pending_requests.push_back(r);
    endtask

    task automatic queue_random_request();
        sched_request_t r;
        int pick;
        r.lvl = ticf_pkg::LVL_W'($urandom_range((1 << ticf_pkg::LVL_W) - 1));
        r.grp = ticf_pkg::GRP_IN_W'($urandom_range((1 << ticf_pkg::GRP_IN_W) - 1));
        r.members = {$urandom, $urandom};
        r.idlers = idle_pattern();
        r.cpu = ticf_pkg::CPU_W'($urandom_range((1 << ticf_pkg::CPU_W) - 1));
        r.flag = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 40)
            r.kind = ticf_pkg::REQ_MARK;
        else if (pick < 65)
            r.kind = ticf_pkg::REQ_NEAR;
        else if (pick < 89)
            r.kind = ticf_pkg::REQ_PUSH;
        else if (pick < 95)
        begin
            r.kind = ticf_pkg::REQ_LOAD;
            if ($urandom_range(1))
                r.members = topology_mask(LAYOUT_BLOCKS, r.grp, ticf_pkg::MAX_GROUPS);
        end
        else if (pick < 97)
            r.kind = ticf_pkg::REQ_FINISH;
        else
            r.kind = ticf_pkg::REQ_W'($urandom_range(ticf_pkg::REQ_PUSH + 1, REQ_TOP));
        pending_requests.push_back(r);
    endtask

    // fresh masks for every group in use, one layout style per level
    task automatic load_topology();
        layout_t style;
        logic [ticf_pkg::MASK_W-1:0] m;
        int l;
        int g;
        int n;
        int pick;
        for (l = 0; l < ticf_pkg::ACTIVE_LEVELS; l++)
        begin
            n = (plan_groups[l] > ticf_pkg::MAX_GROUPS) ? ticf_pkg::MAX_GROUPS
                                                        : plan_groups[l];
            pick = $urandom_range(9);
            style = (pick < 5) ? LAYOUT_BLOCKS : (pick < 8) ? LAYOUT_STRIPES : LAYOUT_SCATTER;
            for (g = 0; g < n; g++)
            begin
                m = topology_mask(style, g, n);
                if ($urandom_range(9) == 0)
                    m[$urandom_range(ticf_pkg::NUM_CPUS - 1)] = 1'b0;
                queue_request(ticf_pkg::REQ_LOAD, l, g, m, idle_pattern(),
                              $urandom_range(ticf_pkg::NUM_CPUS - 1),
                              1'($urandom_range(1)));
            end
        end
    endtask

    task automatic write_group_count(input int idx, input int value);
        @(negedge clk);
        cfg_index <= ticf_pkg::CFG_IDX_W'(idx);
        cfg_data  <= ticf_pkg::CFG_W'(value);
        cfg_valid <= 1'b1;
        cfg_taken = 1'b0;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_group_counts(input int c0, input int c1, input int c2, input int c3);
        int want [ticf_pkg::CFG_REGS];
        int l;
        want[0] = c0;
        want[1] = c1;
        want[2] = c2;
        want[3] = c3;
        for (l = 0; l < ticf_pkg::CFG_REGS; l++)
        begin
            write_group_count(l, want[l]);
            plan_groups[l] = want[l];
        end
        @(posedge clk);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || awaited_answers.size() != 0 || in_valid);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    initial
    begin : clock_gen
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
    begin : feeder
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    on_offer = pending_requests.pop_front();
                    req_type      <= on_offer.kind;
                    level         <= on_offer.lvl;
                    group         <= on_offer.grp;
                    member_mask   <= on_offer.members;
                    idle_mask     <= on_offer.idlers;
                    requester_cpu <= on_offer.cpu;
                    idle_flag     <= on_offer.flag;
                    in_valid      <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            req_taken = 1'b0;
        end
    end

    always @(negedge clk)
    begin : sink
        if (hold_ticket != hold_seen)
        begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        sched_answer_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with nothing pending, got found %0b cpu %0d status %0d",
                             $time, found, cpu_id, status);
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (found !== want.found)
                    begin
                        error_count++;
                        $display("%0t: found expected %0b got %0b", $time, want.found, found);
                    end
                    if (cpu_id !== want.cpu)
                    begin
                        error_count++;
                        $display("%0t: cpu_id expected %0d got %0d", $time, want.cpu, cpu_id);
                    end
                    if (status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status expected %0d got %0d", $time, want.status, status);
                    end
                end
            end
            // input transfer
            if (in_valid && in_ready)
            begin
                awaited_answers.push_back(idle_cpu_answer(on_offer));
                req_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                shadow_groups[cfg_index] = cfg_data;
                cfg_taken = 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : sequencer
        int l;
        int g;
        int p;
        for (l = 0; l < ticf_pkg::CFG_REGS; l++)
        begin
            shadow_groups[l] = ticf_pkg::CFG_W'(1);
            plan_groups[l] = 1;
        end
        for (l = 0; l < ticf_pkg::NUM_LEVELS; l++)
            for (g = 0; g < ticf_pkg::MAX_GROUPS; g++)
            begin
                shadow_members[l][g] = '0;
                shadow_idle[l][g] = '0;
            end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(14, 85);
        apply_group_counts(4, 2, 1, 1);
        for (g = 0; g < 4; g++)
            queue_request(ticf_pkg::REQ_LOAD, 0, g, topology_mask(LAYOUT_BLOCKS, g, 4), '0,
                          0, 1'b0);
        for (g = 0; g < 2; g++)
            queue_request(ticf_pkg::REQ_LOAD, 1, g, topology_mask(LAYOUT_BLOCKS, g, 2), '0,
                          0, 1'b0);
        queue_request(ticf_pkg::REQ_LOAD, 2, 0, '1, '0, 0, 1'b0);
        queue_request(ticf_pkg::REQ_LOAD, 3, 0, '1, '0, 0, 1'b0);
        // not ready yet
        queue_request(ticf_pkg::REQ_MARK, 0, 0, '0, '0, 0, 1'b1);
        queue_request(ticf_pkg::REQ_NEAR, 0, 0, '0, '0, 63, 1'b0);
        queue_request(ticf_pkg::REQ_PUSH, 0, 0, '0, '0, 0, 1'b0);
        queue_request(REQ_TOP, 3, 15, '1, '1, 63, 1'b1);
        queue_request(ticf_pkg::REQ_FINISH, 0, 0, '0, '0, 0, 1'b0);
        // nothing idle
        queue_request(ticf_pkg::REQ_NEAR, 0, 0, '0, '0, 0, 1'b0);
        queue_request(ticf_pkg::REQ_PUSH, 0, 0, '0, '0, 63, 1'b0);
        queue_request(ticf_pkg::REQ_MARK, 0, 0, '0, '0, 63, 1'b1);
        queue_request(ticf_pkg::REQ_NEAR, 0, 0, '0, '0, 48, 1'b0);
        queue_request(ticf_pkg::REQ_PUSH, 0, 0, '0, '0, 0, 1'b0);
        queue_request(ticf_pkg::REQ_MARK, 0, 0, '0, '0, 0, 1'b1);
        queue_request(ticf_pkg::REQ_NEAR, 0, 0, '0, '0, 63, 1'b0);
        queue_request(ticf_pkg::REQ_NEAR, 0, 0, '0, '0, 20, 1'b0);
        queue_request(ticf_pkg::REQ_MARK, 0, 0, '0, '0, 63, 1'b0);
        queue_request(ticf_pkg::REQ_PUSH, 0, 0, '0, '0, 63, 1'b0);
        // cpus 0..15 drop out of every level 0 group
        queue_request(ticf_pkg::REQ_LOAD, 0, 0, '0, '1, 0, 1'b0);
        queue_request(ticf_pkg::REQ_NEAR, 0, 0, '0, '0, 5, 1'b0);
        queue_request(ticf_pkg::REQ_MARK, 0, 0, '0, '0, 5, 1'b1);
        queue_request(ticf_pkg::REQ_PUSH, 0, 0, '0, '0, 40, 1'b0);

        for (p = 0; p < 8; p++)
        begin
            wait_drained();
            if (p == 3)
                set_idling(85, 14);
            else if (p == 6)
                set_idling(0, 0);
            case (p)
                0: apply_group_counts(16, 16, 16, 16);
                1: apply_group_counts(1, 1, 1, 1);
                2: apply_group_counts($urandom_range(1, 16), $urandom_range(1, 16),
                                      $urandom_range(1, 16), $urandom_range(1, 16));
                3: apply_group_counts(8, 4, 2, 1);
                4: apply_group_counts(0, $urandom_range(1, 16), $urandom_range(1, 16), 1);
                5: apply_group_counts(31, $urandom_range(1, 16), 2, 1);
                6: apply_group_counts($urandom_range(1, 16), $urandom_range(1, 16),
                                      $urandom_range(1, 16), $urandom_range(1, 16));
                default: apply_group_counts(2, 2, 2, 2);
            endcase
            if (p == 6)
                hold_ticket++;
            load_topology();
            repeat ((p == 4) ? SHORT_ITEMS : PHASE_ITEMS)
                queue_random_request();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: topology_idle_cpu_finder.f
rtl/ticf_pkg.sv
rtl/ticf_mem.sv
rtl/ticf_ffs.sv
rtl/topology_idle_cpu_finder.sv
verif/topology_idle_cpu_finder_test.sv
